/* rtl/dmcba_pkg.sv */
package dmcba_pkg;

  localparam int ADDR_BITS_DEF   = 48;
  localparam int REGIONS_DEF     = 2;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int TOTAL_BITS      = 49;
  localparam int OP_BITS         = 2;
  localparam int STATUS_BITS     = 2;
  localparam int PAGE_SHIFT_BITS = 6;

  typedef logic [OP_BITS-1:0]         op_t;
  typedef logic [STATUS_BITS-1:0]     status_t;
  typedef logic [PAGE_SHIFT_BITS-1:0] page_shift_t;

  localparam op_t OP_ALLOC     = 2'd0;
  localparam op_t OP_OWNS      = 2'd1;
  localparam op_t OP_CONTAINS  = 2'd2;
  localparam op_t OP_TRANSLATE = 2'd3;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FAIL  = 2'd1;
  localparam status_t STATUS_FAULT = 2'd2;

  // register map: three registers per region, then page shift and enable
  localparam int CFG_EXEC_BASE  = 0;
  localparam int CFG_WRITE_BASE = 1;
  localparam int CFG_LENGTH     = 2;
  localparam int CFG_PER_REGION = 3;
  localparam int CFG_PAGE_SHIFT = 0;  // offset after the region block
  localparam int CFG_ENABLE     = 1;

  localparam page_shift_t PAGE_SHIFT_RESET = 6'd12;

endpackage

/* rtl/dual_mapped_code_bump_allocator.sv */
// Bump allocator over REGIONS dual-mapped code regions.
// Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle, no
// wait; registers 3r..3r+2 are exec base, write base and length of region r,
// then page shift and arena enable. Write only while no request is in flight.
// Requests: a transfer happens on a clock edge with start high and busy low.
// in_op selects alloc, owns, contains or translate.
// Results: out_valid pulses for one cycle with status, address, total used
// bytes and the saturating allocation count after that request.
// Timing: the input register loads at the transfer edge and the result
// register, together with out_valid, at the next edge; the receiver takes
// the result while out_valid is high.
// Throughput: one request per cycle while busy is low; the used counters are read
// and bumped in the same cycle, so back-to-back allocs see each other.
// Reset: synchronous on rst_n; region registers, used counters and the count
// clear, page shift returns to 12, the arena is disabled. busy is high during
// reset and clears at the clock edge after rst_n rises, then stays low.
// The receiver takes every result; there is no back-pressure on out_valid.
module dual_mapped_code_bump_allocator #(
  parameter int ADDR_BITS  = dmcba_pkg::ADDR_BITS_DEF,
  parameter int REGIONS    = dmcba_pkg::REGIONS_DEF,
  parameter int COUNT_BITS = dmcba_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [$clog2(3*REGIONS+2)-1:0]        cfg_index,
  input  logic [ADDR_BITS-1:0]                  cfg_wdata,
  input  logic                                  start,
  output logic                                  busy,
  input  dmcba_pkg::op_t                        in_op,
  input  logic [ADDR_BITS-1:0]                  in_request_address,
  input  logic [ADDR_BITS-1:0]                  in_request_length,
  output logic                                  out_valid,
  output dmcba_pkg::status_t                    out_status,
  output logic [ADDR_BITS-1:0]                  out_result_address,
  output logic [dmcba_pkg::TOTAL_BITS-1:0]      out_total_used,
  output logic [COUNT_BITS-1:0]                 out_allocation_count
);
  import dmcba_pkg::*;

  localparam int CFG_IDX_BITS = $clog2(3*REGIONS+2);
  localparam int REG_IDX_BITS = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int PAGE_SHIFT_IDX = CFG_PER_REGION*REGIONS + CFG_PAGE_SHIFT;
  localparam int ENABLE_IDX     = CFG_PER_REGION*REGIONS + CFG_ENABLE;
  localparam logic [ADDR_BITS-1:0]  ADDR_ONES  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONES = '1;

  // per-region translate outcome
  localparam logic [1:0] TR_NONE  = 2'd0;
  localparam logic [1:0] TR_MAP   = 2'd1;
  localparam logic [1:0] TR_FAULT = 2'd2;

  typedef logic [ADDR_BITS-1:0] addr_t;

  // configuration
  addr_t       exec_base_r  [REGIONS];
  addr_t       write_base_r [REGIONS];
  addr_t       length_r     [REGIONS];
  page_shift_t page_shift_r;
  logic        enable_r;

  // state
  addr_t                  used_r [REGIONS];
  logic [TOTAL_BITS-1:0]  total_r;
  logic [COUNT_BITS-1:0]  count_r;

  // input register
  logic  busy_r;
  logic  in_valid_r;
  op_t   op_r;
  addr_t addr_r;
  addr_t len_r;

  // result register
  logic                  out_valid_r;
  status_t               status_r;
  addr_t                 res_addr_r;
  logic [TOTAL_BITS-1:0] res_total_r;
  logic [COUNT_BITS-1:0] res_count_r;

  // compute
  addr_t                    page_m1;
  logic [ADDR_BITS:0]       round_sum;
  addr_t                    rounded;
  logic                     alloc_ok;
  logic [REGIONS-1:0]       fit;
  logic [REGIONS-1:0]       own;
  logic [REGIONS-1:0]       cont;
  logic [1:0]               tr_code [REGIONS];
  addr_t                    off_e   [REGIONS];
  addr_t                    off_w   [REGIONS];
  logic                     alloc_hit;
  logic [REG_IDX_BITS-1:0]  alloc_sel;
  logic                     tr_any;
  logic [REG_IDX_BITS-1:0]  tr_sel;
  logic [ADDR_BITS:0]       span_end;
  logic                     do_bump;
  status_t                  status_nxt;
  addr_t                    res_addr_nxt;
  logic [TOTAL_BITS-1:0]    total_nxt;
  logic [COUNT_BITS-1:0]    count_nxt;

  wire accept = start && !busy_r;

  function automatic logic spans_meet(addr_t a, addr_t n, addr_t b, addr_t m);
    logic a_low;
    logic b_low;
    a_low = (a < b) || ((a - b) < m);
    b_low = (b < a) || ((b - a) < n);
    return (n != '0) && (m != '0) && a_low && b_low;
  endfunction

  // alloc rounding
  always_comb begin
    page_m1   = ~(ADDR_ONES << page_shift_r);
    round_sum = {1'b0, len_r} + {1'b0, page_m1};
    rounded   = round_sum[ADDR_BITS-1:0] & ~page_m1;
    alloc_ok  = enable_r && (len_r != '0) && !round_sum[ADDR_BITS] &&
                ({1'b0, page_shift_r} <= 7'(ADDR_BITS));
  end

  // per-region tests
  always_comb begin
    for (int i = 0; i < REGIONS; i++) begin
      fit[i]   = alloc_ok && (used_r[i] <= length_r[i]) &&
                 (rounded <= length_r[i] - used_r[i]);
      off_e[i] = addr_r - exec_base_r[i];
      off_w[i] = addr_r - write_base_r[i];
      own[i]   = (addr_r >= exec_base_r[i]) && (off_e[i] < length_r[i]);
      cont[i]  = (addr_r >= exec_base_r[i]) && (off_e[i] <= used_r[i]) &&
                 (len_r <= used_r[i] - off_e[i]);
      if (own[i]) begin
        tr_code[i] = (len_r > length_r[i] - off_e[i]) ? TR_FAULT : TR_MAP;
      end else if (spans_meet(addr_r, len_r, exec_base_r[i], length_r[i])) begin
        tr_code[i] = TR_FAULT;
      end else if (spans_meet(addr_r, len_r, write_base_r[i], length_r[i]) &&
                   !((addr_r >= write_base_r[i]) && (off_w[i] <= length_r[i]) &&
                     (len_r <= length_r[i] - off_w[i]))) begin
        // partly covers a write view
        tr_code[i] = TR_FAULT;
      end else begin
        tr_code[i] = TR_NONE;
      end
    end
  end

  // lowest-numbered region wins
  always_comb begin
    alloc_hit = 1'b0;
    alloc_sel = '0;
    tr_any    = 1'b0;
    tr_sel    = '0;
    for (int i = REGIONS-1; i >= 0; i--) begin
      if (fit[i]) begin
        alloc_hit = 1'b1;
        alloc_sel = REG_IDX_BITS'(i);
      end
      if (tr_code[i] != TR_NONE) begin
        tr_any = 1'b1;
        tr_sel = REG_IDX_BITS'(i);
      end
    end
  end

  always_comb begin
    span_end     = {1'b0, addr_r} + {1'b0, len_r};
    status_nxt   = STATUS_FAIL;
    res_addr_nxt = '0;
    do_bump      = 1'b0;
    case (op_r)
      OP_ALLOC: begin
        if (alloc_hit) begin
          status_nxt   = STATUS_OK;
          res_addr_nxt = exec_base_r[alloc_sel] + used_r[alloc_sel];
          do_bump      = in_valid_r;
        end
      end
      OP_OWNS: begin
        status_nxt = (|own) ? STATUS_OK : STATUS_FAIL;
      end
      OP_CONTAINS: begin
        status_nxt = ((len_r != '0) && (|cont)) ? STATUS_OK : STATUS_FAIL;
      end
      OP_TRANSLATE: begin
        if (span_end[ADDR_BITS]) begin
          status_nxt = STATUS_FAULT;
        end else if (tr_any && (tr_code[tr_sel] == TR_FAULT)) begin
          status_nxt = STATUS_FAULT;
        end else if (tr_any) begin
          status_nxt   = STATUS_OK;
          res_addr_nxt = write_base_r[tr_sel] + off_e[tr_sel];
        end else begin
          // untouched address passes through
          status_nxt   = STATUS_OK;
          res_addr_nxt = addr_r;
        end
      end
      default: begin
        status_nxt = STATUS_FAIL;
      end
    endcase
    total_nxt = do_bump ? total_r + TOTAL_BITS'(rounded) : total_r;
    count_nxt = (do_bump && (count_r != COUNT_ONES)) ? count_r + 1'b1 : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < REGIONS; r++) begin
        exec_base_r[r]  <= '0;
        write_base_r[r] <= '0;
        length_r[r]     <= '0;
      end
      page_shift_r <= PAGE_SHIFT_RESET;
      enable_r     <= 1'b0;
    end else if (cfg_we) begin
      for (int r = 0; r < REGIONS; r++) begin
        if (cfg_index == CFG_IDX_BITS'(CFG_PER_REGION*r + CFG_EXEC_BASE)) begin
          exec_base_r[r] <= cfg_wdata;
        end
        if (cfg_index == CFG_IDX_BITS'(CFG_PER_REGION*r + CFG_WRITE_BASE)) begin
          write_base_r[r] <= cfg_wdata;
        end
        if (cfg_index == CFG_IDX_BITS'(CFG_PER_REGION*r + CFG_LENGTH)) begin
          length_r[r] <= cfg_wdata;
        end
      end
      if (cfg_index == CFG_IDX_BITS'(PAGE_SHIFT_IDX)) begin
        page_shift_r <= cfg_wdata[PAGE_SHIFT_BITS-1:0];
      end
      if (cfg_index == CFG_IDX_BITS'(ENABLE_IDX)) begin
        enable_r <= cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < REGIONS; r++) begin
        used_r[r] <= '0;
      end
      total_r     <= '0;
      count_r     <= '0;
      busy_r      <= 1'b1;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_bump) begin
        used_r[alloc_sel] <= used_r[alloc_sel] + rounded;
      end
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      busy_r      <= 1'b0;
      in_valid_r  <= accept;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      addr_r <= in_request_address;
      len_r  <= in_request_length;
    end
    if (in_valid_r) begin
      status_r    <= status_nxt;
      res_addr_r  <= res_addr_nxt;
      res_total_r <= total_nxt;
      res_count_r <= count_nxt;
    end
  end

  assign busy                 = busy_r;
  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_result_address   = res_addr_r;
  assign out_total_used       = res_total_r;
  assign out_allocation_count = res_count_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("request transfer without a result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching request transfer");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STATUS_OK)) |-> (out_result_address == '0))
    else $error("failed result carries an address");

  a_count_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      $past(in_valid_r && (op_r == OP_ALLOC) && (status_nxt == STATUS_OK)))
    else $error("allocation count moved without a successful alloc");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import dmcba_pkg::*;

  localparam int AW = ADDR_BITS_DEF;
  localparam int CW = COUNT_BITS_DEF;
  localparam int REG_COUNT = REGIONS_DEF * CFG_PER_REGION + 2;
  localparam int IDX_W = $clog2(REG_COUNT);
  localparam int REG_SHIFT = REGIONS_DEF * CFG_PER_REGION + CFG_PAGE_SHIFT;
  localparam int REG_ENABLE = REGIONS_DEF * CFG_PER_REGION + CFG_ENABLE;
  localparam logic [63:0] AMASK = (64'd1 << AW) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    status_t               status;
    logic [AW-1:0]         addr;
    logic [TOTAL_BITS-1:0] total;
    logic [CW-1:0]         count;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [AW-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  op_t in_op = OP_OWNS;
  logic [AW-1:0] in_request_address = '0;
  logic [AW-1:0] in_request_length = '0;
  logic out_valid;
  status_t out_status;
  logic [AW-1:0] out_result_address;
  logic [TOTAL_BITS-1:0] out_total_used;
  logic [CW-1:0] out_allocation_count;

  // arena copy kept by the testbench
  logic [AW-1:0] exec_q [REGIONS_DEF];
  logic [AW-1:0] wr_q [REGIONS_DEF];
  logic [AW-1:0] len_q [REGIONS_DEF];
  logic [AW-1:0] used_q [REGIONS_DEF];
  logic [5:0] shift_q;
  logic en_q;
  logic [CW-1:0] allocs_q;

  reply_t replies_due [$];
  reply_t head_reply;
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 1'b0;
  bit wide_q = 1'b0;
  logic [63:0] unit_q = 64'd4096;

  dual_mapped_code_bump_allocator u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .start                (start),
    .busy                 (busy),
    .in_op                (in_op),
    .in_request_address   (in_request_address),
    .in_request_length    (in_request_length),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_result_address   (out_result_address),
    .out_total_used       (out_total_used),
    .out_allocation_count (out_allocation_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("dual_mapped_code_bump_allocator: mismatch");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatches < 40)
      $display("error at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        flag_mismatch("result with nothing outstanding", 64'(out_status), 64'd0);
      end else begin
        head_reply = replies_due.pop_front();
        if (out_status !== head_reply.status)
          flag_mismatch("status", 64'(out_status), 64'(head_reply.status));
        if (out_result_address !== head_reply.addr)
          flag_mismatch("result_address", 64'(out_result_address),
                        64'(head_reply.addr));
        if (out_total_used !== head_reply.total)
          flag_mismatch("total_used", 64'(out_total_used), 64'(head_reply.total));
        if (out_allocation_count !== head_reply.count)
          flag_mismatch("allocation_count", 64'(out_allocation_count),
                        64'(head_reply.count));
      end
    end
  end

  function automatic logic [63:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v & AMASK;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // exact overlap of [a, a+n) and [b, b+m), both non-empty
  function automatic bit spans_meet(input logic [63:0] a, input logic [63:0] n,
                                    input logic [63:0] b, input logic [63:0] m);
    bit ab;
    bit ba;
    ab = (a < b) || (a - b < m);
    ba = (b < a) || (b - a < n);
    return n != 0 && m != 0 && ab && ba;
  endfunction

  task automatic arena_reset();
    for (int i = 0; i < REGIONS_DEF; i++) begin
      exec_q[i] = '0;
      wr_q[i] = '0;
      len_q[i] = '0;
      used_q[i] = '0;
    end
    shift_q = PAGE_SHIFT_RESET;
    en_q = 1'b0;
    allocs_q = '0;
  endtask

  task automatic arena_cfg(input int idx, input logic [AW-1:0] v);
    int r;
    r = idx / CFG_PER_REGION;
    if (idx < REGIONS_DEF * CFG_PER_REGION) begin
      case (idx % CFG_PER_REGION)
        CFG_EXEC_BASE:  exec_q[r] = v;
        CFG_WRITE_BASE: wr_q[r] = v;
        CFG_LENGTH:     len_q[r] = v;
        default: ;
      endcase
    end else if (idx == REG_SHIFT) begin
      shift_q = v[5:0];
    end else if (idx == REG_ENABLE) begin
      en_q = v[0];
    end
  endtask

  // one request against the arena copy; updates used bytes and the count
  task automatic arena_step(input op_t op, input logic [AW-1:0] pa,
                            input logic [AW-1:0] la, output reply_t r);
    logic [63:0] p, len, page, rounded, room, off, rl, eb, wb, u, addr;
    status_t st;
    bit done;
    p = 64'(pa);
    len = 64'(la);
    addr = 64'd0;
    st = STATUS_FAIL;
    done = 1'b0;
    case (op)
      OP_ALLOC: begin
        page = 64'd1 << shift_q;
        if (en_q && len != 0 && page - 1 <= AMASK && len <= AMASK - (page - 1)) begin
          rounded = (len + page - 1) & ~(page - 1);
          for (int i = 0; i < REGIONS_DEF; i++) begin
            u = 64'(used_q[i]);
            rl = 64'(len_q[i]);
            room = (u <= rl) ? rl - u : 64'd0;
            if (!done && rounded <= room) begin
              done = 1'b1;
              addr = (64'(exec_q[i]) + u) & AMASK;
              used_q[i] = AW'(u + rounded);
              if (allocs_q != '1) allocs_q = allocs_q + 1'b1;
              st = STATUS_OK;
            end
          end
        end
      end
      OP_OWNS: begin
        for (int i = 0; i < REGIONS_DEF; i++) begin
          eb = 64'(exec_q[i]);
          if (p >= eb && p - eb < 64'(len_q[i])) st = STATUS_OK;
        end
      end
      OP_CONTAINS: begin
        for (int i = 0; i < REGIONS_DEF; i++) begin
          eb = 64'(exec_q[i]);
          u = 64'(used_q[i]);
          if (len != 0 && p >= eb) begin
            off = p - eb;
            if (off <= u && len <= u - off) st = STATUS_OK;
          end
        end
      end
      default: begin
        if (len > AMASK - p) begin
          st = STATUS_FAULT;
          done = 1'b1;
        end
        for (int i = 0; i < REGIONS_DEF; i++) begin
          eb = 64'(exec_q[i]);
          wb = 64'(wr_q[i]);
          rl = 64'(len_q[i]);
          if (done) begin
          end else if (p >= eb && p - eb < rl) begin
            off = p - eb;
            done = 1'b1;
            if (len > rl - off) begin
              st = STATUS_FAULT;
            end else begin
              st = STATUS_OK;
              addr = (wb + off) & AMASK;
            end
          end else if (spans_meet(p, len, eb, rl)) begin
            done = 1'b1;
            st = STATUS_FAULT;
          end else if (spans_meet(p, len, wb, rl) &&
                       !(p >= wb && p - wb <= rl && len <= rl - (p - wb))) begin
            // partly covers the write view
            done = 1'b1;
            st = STATUS_FAULT;
          end
        end
        if (!done) begin
          st = STATUS_OK;
          addr = p;
        end
      end
    endcase
    if (st != STATUS_OK) addr = 64'd0;
    r.status = st;
    r.addr = addr[AW-1:0];
    r.total = {1'b0, used_q[0]} + {1'b0, used_q[1]};
    r.count = allocs_q;
  endtask

  // called at a clock edge; leaves start high when the next transfer follows at once
  task automatic send_request(input op_t op, input logic [AW-1:0] a,
                              input logic [AW-1:0] n);
    reply_t r;
    int gap;
    start <= 1'b1;
    in_op <= op;
    in_request_address <= a;
    in_request_length <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    arena_step(op, a, n, r);
    replies_due.push_back(r);
    gap = no_idle ? 0 : idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle_arena();
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_arena(input logic [AW-1:0] e0, input logic [AW-1:0] w0,
                               input logic [AW-1:0] l0, input logic [AW-1:0] e1,
                               input logic [AW-1:0] w1, input logic [AW-1:0] l1,
                               input logic [AW-1:0] sh, input logic [AW-1:0] en);
    logic [AW-1:0] img [REG_COUNT];
    img[CFG_EXEC_BASE] = e0;
    img[CFG_WRITE_BASE] = w0;
    img[CFG_LENGTH] = l0;
    img[CFG_PER_REGION + CFG_EXEC_BASE] = e1;
    img[CFG_PER_REGION + CFG_WRITE_BASE] = w1;
    img[CFG_PER_REGION + CFG_LENGTH] = l1;
    img[REG_SHIFT] = sh;
    img[REG_ENABLE] = en;
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_wdata <= img[i];
      @(posedge clk);
      arena_cfg(i, img[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_after_reset();
    send_request(OP_ALLOC, 48'h0, 48'h1000);
    send_request(OP_OWNS, 48'h0, 48'h0);
    send_request(OP_TRANSLATE, 48'h1234, 48'h10);
    send_request(OP_TRANSLATE, AMASK[AW-1:0], 48'h1);
    settle_arena();
  endtask

  task automatic test_alloc_paths();
    logic [AW-1:0] e0, w0, e1, w1;
    e0 = 48'h0000_1000_0000;
    w0 = 48'h4000_0000_0000;
    e1 = 48'h8000_0000_0000;
    w1 = 48'hffff_ffff_0000;
    program_arena(e0, w0, 48'h3000, e1, w1, 48'h10000, 48'd12, 48'd1);
    send_request(OP_ALLOC, 48'h0, 48'h0);
    send_request(OP_ALLOC, 48'h0, 48'h1);
    send_request(OP_ALLOC, 48'h0, 48'h1000);
    // spills over to the second region
    send_request(OP_ALLOC, 48'h0, 48'h1001);
    send_request(OP_ALLOC, 48'h0, AMASK[AW-1:0]);
    send_request(OP_ALLOC, 48'h0, 48'hffff_ffff_f000);
    send_request(OP_CONTAINS, e0, 48'h2000);
    send_request(OP_CONTAINS, e0 + 48'h1000, 48'h1001);
    send_request(OP_OWNS, e0 + 48'h2fff, 48'h0);
    send_request(OP_OWNS, e0 + 48'h3000, 48'h0);
    send_request(OP_TRANSLATE, e0 + 48'h10, 48'h20);
    send_request(OP_TRANSLATE, e0 + 48'h2ff0, 48'h20);
    send_request(OP_TRANSLATE, e0 - 48'h10, 48'h20);
    send_request(OP_TRANSLATE, w0 + 48'h100, 48'h100);
    send_request(OP_TRANSLATE, w0 - 48'h8, 48'h10);
    send_request(OP_TRANSLATE, e1, 48'h0);
    send_request(OP_TRANSLATE, w1 + 48'hff00, 48'h100);
    settle_arena();
  endtask

  task automatic test_page_and_shrink();
    logic [AW-1:0] e0, w0, e1, w1;
    e0 = exec_q[0];
    w0 = wr_q[0];
    e1 = exec_q[1];
    w1 = wr_q[1];
    program_arena(e0, w0, 48'h3000, e1, w1, 48'h10000, 48'd0, 48'd1);
    send_request(OP_ALLOC, 48'h0, 48'h3);
    send_request(OP_ALLOC, 48'h0, 48'hffd);
    settle_arena();
    program_arena(e0, w0, 48'h3000, e1, w1, 48'h10000, 48'd47, 48'd1);
    send_request(OP_ALLOC, 48'h0, 48'h1);
    settle_arena();
    program_arena(e0, w0, 48'h3000, e1, w1, 48'h10000, 48'd63, 48'd1);
    send_request(OP_ALLOC, 48'h0, 48'h1);
    settle_arena();
    // region 0 shrunk below its used bytes, arena off
    program_arena(e0, w0, 48'h1000, e1, w1, 48'h10000, 48'd12, 48'd0);
    send_request(OP_ALLOC, 48'h0, 48'h1);
    send_request(OP_OWNS, e0, 48'h0);
    settle_arena();
    program_arena(e0, w0, 48'h1000, e1, w1, 48'h10000, 48'd12, 48'd1);
    send_request(OP_ALLOC, 48'h0, 48'h1);
    send_request(OP_CONTAINS, e0, 48'h3000);
    settle_arena();
  endtask

  function automatic logic [AW-1:0] pick_addr();
    logic [63:0] base, span, off;
    int w;
    w = $urandom_range(0, 3);
    base = (w < 2) ? 64'(exec_q[w]) : 64'(wr_q[w - 2]);
    span = 64'(len_q[w % 2]);
    case ($urandom_range(0, 5))
      0: return AW'(rand48());
      1: return AW'(AMASK - 64'($urandom_range(0, 64)));
      2: off = -64'($urandom_range(1, 64));
      3: off = span + 64'($urandom_range(0, 64)) - 64'd32;
      default: off = rand48() % (span + 1);
    endcase
    return AW'((base + off) & AMASK);
  endfunction

  function automatic logic [AW-1:0] pick_len(input logic [63:0] a);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return AW'(rand48());
      2: return AW'((AMASK - a + 64'($urandom_range(0, 2))) & AMASK);
      5: return AW'(rand48() % (64'(len_q[$urandom_range(0, 1)]) + unit_q + 1));
      default: return AW'($urandom_range(1, 32'(2 * unit_q)));
    endcase
  endfunction

  task automatic random_request();
    op_t op;
    logic [63:0] a, n, base, lim, off;
    int pick, w;
    pick = $urandom_range(0, 99);
    w = $urandom_range(0, 1);
    if (pick < 30) begin
      op = OP_ALLOC;
      a = rand48();
      case ($urandom_range(0, 19))
        0: n = 64'd0;
        1: n = rand48();
        2: n = AMASK - 64'($urandom_range(0, 32'(unit_q)));
        default: n = wide_q ? rand48() % (64'd1 << 41) + 1 :
                              64'($urandom_range(1, 32'(4 * unit_q)));
      endcase
    end else if (pick < 50) begin
      op = OP_OWNS;
      a = 64'(pick_addr());
      n = rand48();
    end else begin
      op = (pick < 75) ? OP_CONTAINS : OP_TRANSLATE;
      if ($urandom_range(0, 9) < 6) begin
        // span that starts inside a region, mostly ending inside it too
        if (op == OP_CONTAINS) begin
          base = 64'(exec_q[w]);
          lim = 64'(used_q[w]);
        end else begin
          base = $urandom_range(0, 1) ? 64'(wr_q[w]) : 64'(exec_q[w]);
          lim = 64'(len_q[w]);
        end
        off = rand48() % (lim + 1);
        a = (base + off) & AMASK;
        n = 1 + rand48() % (lim - off + 1);
      end else begin
        a = 64'(pick_addr());
        n = 64'(pick_len(a));
      end
    end
    send_request(op, a[AW-1:0], n[AW-1:0]);
  endtask

  // disjoint windows, one per quarter of the address space
  task automatic random_arena(input int sh, input bit en, input bit wide);
    logic [63:0] base [4];
    logic [63:0] l0, l1, v, u;
    logic [5:0] sh6;
    int q;
    sh6 = 6'(sh);
    wide_q = wide;
    unit_q = (sh > 20) ? 64'd4096 : (64'd1 << sh);
    q = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++)
      base[k] = (64'((q + k) % 4) << 46) | (rand48() & ((64'd1 << 45) - 1) & ~(unit_q - 1));
    u = wide ? (rand48() % (64'd1 << 30)) : 64'($urandom_range(0, 64));
    l0 = 64'(used_q[0]) + u * unit_q;
    u = wide ? (rand48() % (64'd1 << 30)) : 64'($urandom_range(0, 64));
    l1 = 64'(used_q[1]) + u * unit_q;
    v = rand48();
    program_arena(base[0][AW-1:0], base[1][AW-1:0], l0[AW-1:0], base[2][AW-1:0],
                  base[3][AW-1:0], l1[AW-1:0], {v[AW-1:6], sh6}, {v[AW-1:1], en});
  endtask

  task automatic test_random_phases();
    int sh;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: random_arena(12, 1'b1, 1'b0);
        1: random_arena($urandom_range(0, 16), 1'b1, 1'b0);
        2: random_arena(12, 1'b1, 1'b1);
        3: random_arena(0, 1'b1, 1'b0);
        4: begin
          sh = ($urandom_range(0, 2) == 0) ? 47 : ($urandom_range(0, 1) ? 48 : 63);
          random_arena(sh, 1'($urandom_range(0, 1)), 1'b0);
        end
        default: random_arena($urandom_range(0, 20), 1'b1, 1'b0);
      endcase
      no_idle = (ph == 1);
      for (int i = 0; i < 117; i++) begin
        // let everything in flight come back before going on
        if (ph == 3 && i == 58) settle_arena();
        random_request();
      end
      settle_arena();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    arena_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_alloc_paths();
    test_page_and_shrink();
    test_random_phases();
    settle_arena();
    if (mismatches == 0)
      $display("dual_mapped_code_bump_allocator: match");
    else
      $display("dual_mapped_code_bump_allocator: mismatch");
    $finish;
  end

endmodule

/* files.f */
rtl/dmcba_pkg.sv
rtl/dual_mapped_code_bump_allocator.sv
sim/tb_top.sv
